// ===== sv/pctd_pkg.sv =====
// shared types and constants for the prefix code table decoder
package pctd_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int MAX_CODE_LEN = 16;

    // entries held by one cell of the search chain
    localparam int CELL_ENTRIES = 8;
    localparam int NUM_CELLS    = TABLE_DEPTH / CELL_ENTRIES;

    // field widths
    localparam int IDX_W   = 6;
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 16;
    localparam int LEN_W   = 5;
    localparam int COUNT_W = 7;

    localparam int ACC_W     = MAX_CODE_LEN;
    localparam int CMP_W     = (ACC_W > CODE_W) ? ACC_W : CODE_W;
    localparam int SLOT_W    = $clog2(CELL_ENTRIES);
    localparam int CELL_ID_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int GIDX_W    = $clog2(TABLE_DEPTH) + 1;

    // stream payload layout
    localparam int S_FIELDS_W = IDX_W + SYM_W + CODE_W + LEN_W + 1;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((SYM_W + 7) / 8) * 8;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [SYM_W-1:0] symbol;
    } token_t;

    // table write broadcast to the cells
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  index;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
    } tbl_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_SEARCH,
        ST_RESOLVE
    } state_t;

endpackage

// ===== sv/prefix_code_table_decoder_top.sv =====
// top level of the prefix code table decoder: control, accumulator and cell chain
//
// usage:
//   s_ channel carries one transaction per request. s_tuser selects the kind:
//   0 loads one code table entry, 1 feeds one bit of the coded stream.
//   m_ channel carries decoded symbols (m_tuser = 0) or an error marker
//   (m_tuser = 1, symbol zero) when no code matched within the maximum length.
//   cfg_we / cfg_wdata set the number of table entries searched; write it
//   only while the block is idle.
// flow:
//   a load is taken while idle and produces nothing. a stream bit passes through
//   the launch, search and resolve states: the match token walks the
//   chain of cells one cell per cycle, and the next bit is taken only
//   after the verdict is back, since it depends on whether the accumulator was cleared.
// reset:
//   clears the accumulator, the entry count and all handshake state; table
//   contents are not cleared and must be loaded before use.
// stall:
//   one output register holds a finished result; the next request is still
//   accepted, and a new result waits in the control until the register drains.
module prefix_code_table_decoder_top (
    input  logic                              aclk,
    input  logic                              aresetn,

    // fields from bit 0: entry_index, entry_symbol, entry_code, entry_length,
    // code_bit, zero fill
    input  logic [pctd_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,   // req_type
    input  logic                              s_tvalid,
    output logic                              s_tready,

    output logic [pctd_pkg::M_TDATA_W-1:0]    m_tdata,   // symbol
    output logic                              m_tuser,   // status
    output logic                              m_tvalid,
    input  logic                              m_tready,

    input  logic                              cfg_we,
    input  logic [pctd_pkg::COUNT_W-1:0]      cfg_wdata  // entry_count
);
    import pctd_pkg::*;

    localparam int OFF_SYM  = IDX_W;
    localparam int OFF_CODE = OFF_SYM + SYM_W;
    localparam int OFF_LEN  = OFF_CODE + CODE_W;
    localparam int OFF_BIT  = OFF_LEN + LEN_W;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] limit_reg, limit_next;
    logic [ACC_W-1:0]   acc_bits_reg, acc_bits_next;
    logic [LEN_W-1:0]   acc_len_reg, acc_len_next;

    logic             res_found_reg, res_found_next;
    logic [SYM_W-1:0] res_sym_reg, res_sym_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [SYM_W-1:0] m_sym_reg, m_sym_next;
    logic             m_status_reg, m_status_next;

    // control outputs of the state machine
    logic s_ready_c;
    logic launch_c;
    logic out_load_c;
    logic acc_clear_c;

    logic in_fire;
    logic decode_fire;
    logic out_free;
    logic limit_err;
    logic need_result;

    tbl_wr_t wr;
    token_t  chain [NUM_CELLS+1];

    assign in_fire     = s_tvalid && s_tready;
    assign decode_fire = in_fire && (s_tuser == REQ_DECODE);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign limit_err   = acc_len_reg >= LEN_W'(MAX_CODE_LEN);
    assign need_result = res_found_reg || limit_err;

    // table write broadcast
    assign wr.en     = in_fire && (s_tuser == REQ_LOAD);
    assign wr.index  = s_tdata[IDX_W-1:0];
    assign wr.symbol = s_tdata[OFF_SYM +: SYM_W];
    assign wr.code   = s_tdata[OFF_CODE +: CODE_W];
    assign wr.length = s_tdata[OFF_LEN +: LEN_W];

    // token enters the chain once the new accumulator is in place
    assign chain[0].valid  = launch_c;
    assign chain[0].found  = 1'b0;
    assign chain[0].symbol = '0;

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        pctd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_id  (CELL_ID_W'(c)),
            .wr       (wr),
            .acc_bits (acc_bits_reg),
            .acc_len  (acc_len_reg),
            .limit    (limit_reg),
            .tok_in   (chain[c]),
            .tok_out  (chain[c+1])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (decode_fire) begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (chain[NUM_CELLS].valid) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                if (!need_result || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state machine outputs
    always_comb begin
        s_ready_c   = 1'b0;
        launch_c    = 1'b0;
        out_load_c  = 1'b0;
        acc_clear_c = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready_c = 1'b1;
            end
            ST_LAUNCH: begin
                launch_c = 1'b1;
            end
            ST_SEARCH: begin
            end
            ST_RESOLVE: begin
                out_load_c  = need_result && out_free;
                acc_clear_c = need_result && out_free;
            end
            default: begin
            end
        endcase
    end

    assign s_tready = s_ready_c;

    // entry count, clamped to the table size
    always_comb begin
        limit_next = limit_reg;
        if (cfg_we) begin
            limit_next = (cfg_wdata > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH)
                                                            : cfg_wdata;
        end
    end

    // bit accumulator, first bit most significant
    always_comb begin
        acc_bits_next = acc_bits_reg;
        acc_len_next  = acc_len_reg;
        if (decode_fire) begin
            acc_bits_next = {acc_bits_reg[ACC_W-2:0], s_tdata[OFF_BIT]};
            acc_len_next  = acc_len_reg + LEN_W'(1);
        end else if (acc_clear_c) begin
            acc_bits_next = '0;
            acc_len_next  = '0;
        end
    end

    // capture the verdict at the end of the chain
    always_comb begin
        res_found_next = res_found_reg;
        res_sym_next   = res_sym_reg;
        if ((state_reg == ST_SEARCH) && chain[NUM_CELLS].valid) begin
            res_found_next = chain[NUM_CELLS].found;
            res_sym_next   = chain[NUM_CELLS].symbol;
        end
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_sym_next    = m_sym_reg;
        m_status_next = m_status_reg;
        if (out_load_c) begin
            m_tvalid_next = 1'b1;
            m_sym_next    = res_found_reg ? res_sym_reg : '0;
            m_status_next = res_found_reg ? STATUS_OK : STATUS_ERROR;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            limit_reg    <= '0;
            acc_bits_reg <= '0;
            acc_len_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            limit_reg    <= limit_next;
            acc_bits_reg <= acc_bits_next;
            acc_len_reg  <= acc_len_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        res_found_reg <= res_found_next;
        res_sym_reg   <= res_sym_next;
        m_sym_reg     <= m_sym_next;
        m_status_reg  <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_sym_reg);
    assign m_tuser  = m_status_reg;

endmodule

// ===== sv/pctd_cell.sv =====
// one search cell: a slice of the code table and one stage of the match chain
module pctd_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pctd_pkg::CELL_ID_W-1:0] cell_id,
    input  pctd_pkg::tbl_wr_t             wr,
    input  logic [pctd_pkg::ACC_W-1:0]    acc_bits,
    input  logic [pctd_pkg::LEN_W-1:0]    acc_len,
    input  logic [pctd_pkg::COUNT_W-1:0]  limit,
    input  pctd_pkg::token_t              tok_in,
    output pctd_pkg::token_t              tok_out
);
    import pctd_pkg::*;

    logic [SYM_W-1:0]  sym_mem  [CELL_ENTRIES];
    logic [CODE_W-1:0] code_mem [CELL_ENTRIES];
    logic [LEN_W-1:0]  len_mem  [CELL_ENTRIES];

    logic [CELL_ENTRIES-1:0] hit;
    logic                    local_found;
    logic [SYM_W-1:0]        local_sym;
    logic                    wr_here;

    logic             tok_valid_reg, tok_valid_next;
    logic             tok_found_reg, tok_found_next;
    logic [SYM_W-1:0] tok_sym_reg, tok_sym_next;

    assign wr_here = wr.en && (wr.index[IDX_W-1:SLOT_W] == cell_id[IDX_W-SLOT_W-1:0]);

    always_ff @(posedge aclk) begin
        for (int j = 0; j < CELL_ENTRIES; j++) begin
            if (wr_here && (wr.index[SLOT_W-1:0] == SLOT_W'(j))) begin
                sym_mem[j]  <= wr.symbol;
                code_mem[j] <= wr.code;
                len_mem[j]  <= wr.length;
            end
        end
    end

    // parallel compare of the slice against the accumulator
    always_comb begin
        for (int j = 0; j < CELL_ENTRIES; j++) begin
            hit[j] = (GIDX_W'({cell_id, SLOT_W'(j)}) < GIDX_W'(limit))
                  && (len_mem[j] == acc_len)
                  && (CMP_W'(code_mem[j]) == CMP_W'(acc_bits));
        end
    end

    // lowest entry wins
    always_comb begin
        local_found = 1'b0;
        local_sym   = '0;
        for (int j = CELL_ENTRIES - 1; j >= 0; j--) begin
            if (hit[j]) begin
                local_found = 1'b1;
                local_sym   = sym_mem[j];
            end
        end
    end

    always_comb begin
        tok_valid_next = tok_in.valid;
        tok_found_next = tok_found_reg;
        tok_sym_next   = tok_sym_reg;
        if (tok_in.valid) begin
            tok_found_next = tok_in.found || local_found;
            tok_sym_next   = tok_in.found ? tok_in.symbol : local_sym;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_valid_next;
        end
        tok_found_reg <= tok_found_next;
        tok_sym_reg   <= tok_sym_next;
    end

    assign tok_out.valid  = tok_valid_reg;
    assign tok_out.found  = tok_found_reg;
    assign tok_out.symbol = tok_sym_reg;

endmodule
